FILE: rtl/core/mesh_cell_simplex_split_assert.svh
// Assertion macros used by the checker file.
`ifndef MESH_CELL_SIMPLEX_SPLIT_ASSERT_SVH
`define MESH_CELL_SIMPLEX_SPLIT_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define MCSS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MCSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

FILE: rtl/core/mcss_pkg.sv
// Package: field widths, type codes and split tables for the simplex splitter.
package mcss_pkg;
    localparam int NodeIdBitsDefault = 32;
    localparam int TypeBits = 4;
    localparam int OutBits = 32;

    localparam logic [3:0] TypeQuad = 4'd3;
    localparam logic [3:0] TypeHexa = 4'd5;
    localparam logic [3:0] TypePrism = 4'd8;
    localparam logic [3:0] TypePyramid = 4'd9;

    typedef logic [2:0] corner_t;

    function automatic corner_t hex_renumber(input logic [2:0] m, input logic [2:0] i);
        logic [23:0] row;
        begin
            case (m)
                3'd0: row = {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
                3'd1: row = {3'd6, 3'd7, 3'd3, 3'd2, 3'd5, 3'd4, 3'd0, 3'd1};
                3'd2: row = {3'd7, 3'd4, 3'd0, 3'd3, 3'd6, 3'd5, 3'd1, 3'd2};
                3'd3: row = {3'd6, 3'd5, 3'd4, 3'd7, 3'd2, 3'd1, 3'd0, 3'd3};
                3'd4: row = {3'd6, 3'd2, 3'd1, 3'd5, 3'd7, 3'd3, 3'd0, 3'd4};
                3'd5: row = {3'd7, 3'd3, 3'd2, 3'd6, 3'd4, 3'd0, 3'd1, 3'd5};
                3'd6: row = {3'd4, 3'd0, 3'd3, 3'd7, 3'd5, 3'd1, 3'd2, 3'd6};
                default: row = {3'd5, 3'd1, 3'd0, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7};
            endcase
            return row[i*3 +: 3];
        end
    endfunction

    function automatic corner_t prism_renumber(input logic [2:0] m, input logic [2:0] i);
        logic [17:0] row;
        begin
            case (m)
                3'd0: row = {3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
                3'd1: row = {3'd3, 3'd5, 3'd4, 3'd0, 3'd2, 3'd1};
                3'd2: row = {3'd4, 3'd3, 3'd5, 3'd1, 3'd0, 3'd2};
                3'd3: row = {3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd3};
                3'd4: row = {3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd4};
                default: row = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
            endcase
            return row[i*3 +: 3];
        end
    endfunction

    function automatic corner_t hex_rot(input logic [1:0] r, input logic [2:0] i);
        logic [23:0] row;
        begin
            case (r)
                2'd1: row = {3'd2, 3'd6, 3'd7, 3'd3, 3'd1, 3'd5, 3'd4, 3'd0};
                2'd2: row = {3'd5, 3'd6, 3'd2, 3'd1, 3'd4, 3'd7, 3'd3, 3'd0};
                default: row = {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
            endcase
            return row[i*3 +: 3];
        end
    endfunction

    // Four corner indices of tetrahedron k for diagonal count nd, a in lowest bits.
    function automatic logic [11:0] hex_tet(input logic [1:0] nd, input logic [2:0] k);
        logic [11:0] t;
        begin
            t = '0;
            case ({nd, k})
                5'o00: t = {3'd5, 3'd2, 3'd1, 3'd0};
                5'o01: t = {3'd5, 3'd7, 3'd2, 3'd0};
                5'o02: t = {3'd7, 3'd3, 3'd2, 3'd0};
                5'o03: t = {3'd4, 3'd7, 3'd5, 3'd0};
                5'o04: t = {3'd6, 3'd5, 3'd7, 3'd2};
                5'o10: t = {3'd4, 3'd7, 3'd5, 3'd0};
                5'o11: t = {3'd5, 3'd7, 3'd1, 3'd0};
                5'o12: t = {3'd5, 3'd7, 3'd6, 3'd1};
                5'o13: t = {3'd3, 3'd2, 3'd7, 3'd0};
                5'o14: t = {3'd2, 3'd1, 3'd7, 3'd0};
                5'o15: t = {3'd2, 3'd6, 3'd7, 3'd1};
                5'o20: t = {3'd6, 3'd5, 3'd4, 3'd0};
                5'o21: t = {3'd6, 3'd7, 3'd3, 3'd0};
                5'o22: t = {3'd6, 3'd4, 3'd7, 3'd0};
                5'o23: t = {3'd5, 3'd2, 3'd1, 3'd0};
                5'o24: t = {3'd2, 3'd6, 3'd3, 3'd0};
                5'o25: t = {3'd2, 3'd5, 3'd6, 3'd0};
                5'o30: t = {3'd6, 3'd3, 3'd2, 3'd0};
                5'o31: t = {3'd6, 3'd7, 3'd3, 3'd0};
                5'o32: t = {3'd6, 3'd4, 3'd7, 3'd0};
                5'o33: t = {3'd4, 3'd6, 3'd5, 3'd0};
                5'o34: t = {3'd0, 3'd6, 3'd5, 3'd1};
                5'o35: t = {3'd0, 3'd2, 3'd6, 3'd1};
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    function automatic logic [11:0] prism_tet(input logic sel, input logic [1:0] k);
        logic [11:0] t;
        begin
            case ({sel, k})
                3'b000: t = {3'd5, 3'd2, 3'd1, 3'd0};
                3'b001: t = {3'd4, 3'd5, 3'd1, 3'd0};
                3'b100: t = {3'd4, 3'd2, 3'd1, 3'd0};
                3'b101: t = {3'd5, 3'd2, 3'd4, 3'd0};
                default: t = {3'd3, 3'd5, 3'd4, 3'd0};
            endcase
            return t;
        end
    endfunction
endpackage

FILE: rtl/core/mesh_cell_simplex_split.sv
// Top level of the mesh cell simplex splitter.
//
// One input item on the s_ channel is one mesh cell: a four-bit type code in
// s_axis_tuser and eight node ids in s_axis_tdata. The block emits one result
// item per simplex on the m_ channel: four vertex ids in m_axis_tdata, the
// tetrahedron flag in m_axis_tuser and the final-simplex-of-cell flag in
// m_axis_tlast. Quadrilaterals give two triangles, pyramids two tetrahedra,
// prisms three and hexahedra five or six tetrahedra; other types give none.
// The work runs through four register stages: corner ordering and first
// minimum search, renumbering, diagonal bits and rotation, and finally an
// emitter that holds the rotated cell and sends one simplex per cycle while
// the receiver is ready. A cell passes the stage 1, 2 and 3 registers before
// the emitter offers its first simplex. A new cell can enter every cycle
// while the stages ahead can advance; the sustained rate is set by the
// emitter, which holds each cell until its last simplex is taken, while a
// cell with no simplices passes without holding it. When the receiver stalls
// the stages fill and s_axis_tready falls; nothing is lost or repeated.
// Synchronous reset clears all valid bits and the emitter count.
module mesh_cell_simplex_split #(
    parameter int NODE_ID_BITS = mcss_pkg::NodeIdBitsDefault
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // node_0 .. node_7, 32 bits each, node_0 lowest
    input  logic [255:0]  s_axis_tdata,
    // element_type
    input  logic [3:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // vertex_a, vertex_b, vertex_c, vertex_d, 32 bits each, vertex_a lowest
    output logic [127:0]  m_axis_tdata,
    // is_tetra
    output logic          m_axis_tuser,
    // last_simplex
    output logic          m_axis_tlast
);
    import mcss_pkg::*;

    localparam int IdW = (NODE_ID_BITS < OutBits) ? NODE_ID_BITS : OutBits;
    typedef logic [IdW-1:0] id_t;
    typedef id_t [7:0] cell_t;

    function automatic id_t mn(input id_t a, input id_t b);
        return (a < b) ? a : b;
    endfunction

    // Stage 1: corners in working order, minimum index.
    logic       v1_reg;
    logic [3:0] t1_reg;
    cell_t      p1_reg;
    logic [2:0] m1_reg;
    // Stage 2: renumbered cell.
    logic       v2_reg;
    logic [3:0] t2_reg;
    cell_t      p2_reg;
    // Stage 3: rotated cell and split selection.
    logic       v3_reg;
    logic [3:0] t3_reg;
    cell_t      p3_reg;
    logic [1:0] nd3_reg;
    logic       sel3_reg;
    // Emitter.
    logic       ve_reg;
    logic [3:0] te_reg;
    cell_t      pe_reg;
    logic [1:0] nde_reg;
    logic       sele_reg;
    logic [2:0] k_reg;

    logic [2:0] cnt;
    logic       em_done, em_free, adv3, adv2, adv1;
    cell_t      p1_next, p2_next, p3_next;
    logic [2:0] m1_next;
    logic [1:0] nd3_next;
    logic       sel3_next;
    logic [2:0] rb;

    always_comb begin
        case (te_reg)
            TypeQuad, TypePyramid: cnt = 3'd2;
            TypePrism: cnt = 3'd3;
            TypeHexa: cnt = (nde_reg == 2'd0) ? 3'd5 : 3'd6;
            default: cnt = 3'd0;
        endcase
    end

    assign em_done = (cnt == 3'd0) || (m_axis_tready && (k_reg == cnt - 3'd1));
    assign em_free = !ve_reg || em_done;
    assign adv3 = em_free;
    assign adv2 = !v3_reg || adv3;
    assign adv1 = !v2_reg || adv2;
    assign s_axis_tready = !v1_reg || adv1;

    // Stage 1 logic. The minimum is found by a three-level tree in which the
    // lower index wins a tie, so the first smallest corner is kept.
    always_comb begin
        id_t e [8];
        logic [2:0] w01, w23, w45, w67, wlo, whi;
        for (int i = 0; i < 8; i++) begin
            e[i] = s_axis_tdata[i*32 +: IdW];
        end
        p1_next = '{e[6], e[7], e[5], e[4], e[2], e[3], e[1], e[0]};
        if (s_axis_tuser == TypePyramid) begin
            p1_next = '{e[7], e[6], e[5], e[4], e[2], e[3], e[1], e[0]};
        end else if (s_axis_tuser != TypeHexa) begin
            p1_next = '{e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};
        end
        w01 = (p1_next[1] < p1_next[0]) ? 3'd1 : 3'd0;
        w23 = (p1_next[3] < p1_next[2]) ? 3'd3 : 3'd2;
        w45 = (p1_next[5] < p1_next[4]) ? 3'd5 : 3'd4;
        w67 = (p1_next[7] < p1_next[6]) ? 3'd7 : 3'd6;
        wlo = (p1_next[w23] < p1_next[w01]) ? w23 : w01;
        // Only a hexahedron takes part with corners six and seven.
        whi = (s_axis_tuser == TypeHexa && p1_next[w67] < p1_next[w45]) ? w67 : w45;
        m1_next = (p1_next[whi] < p1_next[wlo]) ? whi : wlo;
    end

    // Stage 2 logic.
    always_comb begin
        p2_next = p1_reg;
        for (int i = 0; i < 8; i++) begin
            if (t1_reg == TypeHexa) begin
                p2_next[i] = p1_reg[hex_renumber(m1_reg, 3'(i))];
            end else if (t1_reg == TypePrism && i < 6) begin
                p2_next[i] = p1_reg[prism_renumber(m1_reg, 3'(i))];
            end
        end
    end

    // Stage 3 logic.
    always_comb begin
        logic [1:0] r;
        rb[2] = mn(p2_reg[1], p2_reg[6]) < mn(p2_reg[2], p2_reg[5]);
        rb[1] = mn(p2_reg[3], p2_reg[6]) < mn(p2_reg[2], p2_reg[7]);
        rb[0] = mn(p2_reg[4], p2_reg[6]) < mn(p2_reg[5], p2_reg[7]);
        case (rb)
            3'd1, 3'd6: r = 2'd1;
            3'd2, 3'd5: r = 2'd2;
            default: r = 2'd0;
        endcase
        case (rb)
            3'd0: nd3_next = 2'd0;
            3'd7: nd3_next = 2'd3;
            3'd1, 3'd2, 3'd4: nd3_next = 2'd1;
            default: nd3_next = 2'd2;
        endcase
        p3_next = p2_reg;
        if (t2_reg == TypeHexa) begin
            for (int i = 0; i < 8; i++) begin
                p3_next[i] = p2_reg[hex_rot(r, 3'(i))];
            end
        end
        // Quad and pyramid use the base diagonal; prism uses its own test.
        if (t2_reg == TypePrism) begin
            sel3_next = !(mn(p2_reg[1], p2_reg[5]) < mn(p2_reg[2], p2_reg[4]));
        end else begin
            sel3_next = !(mn(p2_reg[0], p2_reg[2]) < mn(p2_reg[1], p2_reg[3]));
        end
    end

    // Emitter output selection.
    always_comb begin
        logic [11:0] t;
        id_t a, b, c, d;
        t = '0;
        case (te_reg)
            TypeHexa: t = hex_tet(nde_reg, k_reg);
            TypePrism: t = prism_tet(sele_reg, k_reg[1:0]);
            default: begin
                if (!sele_reg) begin
                    t = (k_reg == 3'd0) ? {3'd4, 3'd2, 3'd1, 3'd0} : {3'd4, 3'd3, 3'd2, 3'd0};
                end else begin
                    t = (k_reg == 3'd0) ? {3'd4, 3'd3, 3'd2, 3'd1} : {3'd4, 3'd0, 3'd3, 3'd1};
                end
            end
        endcase
        a = pe_reg[t[2:0]];
        b = pe_reg[t[5:3]];
        c = pe_reg[t[8:6]];
        d = (te_reg == TypeQuad) ? '0 : pe_reg[t[11:9]];
        m_axis_tdata = {32'(d), 32'(c), 32'(b), 32'(a)};
        m_axis_tuser = (te_reg != TypeQuad);
        m_axis_tlast = (k_reg == cnt - 3'd1);
    end
    assign m_axis_tvalid = ve_reg && (cnt != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ve_reg <= 1'b0;
            k_reg  <= 3'd0;
        end else begin
            if (s_axis_tready) begin
                v1_reg <= s_axis_tvalid;
                t1_reg <= s_axis_tuser;
                p1_reg <= p1_next;
                m1_reg <= m1_next;
            end
            if (adv1) begin
                v2_reg <= v1_reg;
                t2_reg <= t1_reg;
                p2_reg <= p2_next;
            end
            if (adv2) begin
                v3_reg   <= v2_reg;
                t3_reg   <= t2_reg;
                p3_reg   <= p3_next;
                nd3_reg  <= nd3_next;
                sel3_reg <= sel3_next;
            end
            if (adv3) begin
                ve_reg   <= v3_reg;
                te_reg   <= t3_reg;
                pe_reg   <= p3_reg;
                nde_reg  <= nd3_reg;
                sele_reg <= sel3_reg;
                k_reg    <= 3'd0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                k_reg <= k_reg + 3'd1;
            end
        end
    end
endmodule

FILE: rtl/core/mcss_checker.sv
// Port-level checker for the simplex splitter, bound to the top level.
`include "mesh_cell_simplex_split_assert.svh"
module mcss_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic         m_axis_tuser,
    input logic         m_axis_tlast
);
    `MCSS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `MCSS_ASSERT_IMPL(a_tri_d_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[127:96] == 32'd0)
    `MCSS_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_axis_tvalid && !$past(s_axis_tvalid), s_axis_tready)
    `MCSS_ASSERT_NEXT(a_tri_pair, aclk, aresetn, m_axis_tvalid && m_axis_tready && !m_axis_tuser && !m_axis_tlast, !m_axis_tuser)
endmodule

bind mesh_cell_simplex_split mcss_checker u_mcss_checker (.*);

FILE: verif/tb_mesh_cell_simplex_split.sv
// Self-checking testbench for the mesh cell simplex splitter.
module tb_mesh_cell_simplex_split;
    timeunit 1ns;
    timeprecision 1ps;
    import mcss_pkg::*;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic        tet;
        logic        last;
    } simplex_t;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] nd [8];
        int          n_known;
        simplex_t    known [2];
    } cell_row_t;

    localparam int RandomCells = 140;
    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 20;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;
    logic [3:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    simplex_t pending_simplices [$];
    int       n_errors = 0;
    int       cycle_count;
    bit       stim_done;
    bit       long_stall_req;
    bit       stall_done;

    mesh_cell_simplex_split u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [31:0] lower_of(logic [31:0] x, logic [31:0] y);
        return (x < y) ? x : y;
    endfunction

    // Index of the first smallest id among the first n entries.
    function automatic int first_lowest(logic [31:0] p [8], int n);
        int best;
        best = 0;
        for (int i = 1; i < n; i++) begin
            if (p[i] < p[best]) best = i;
        end
        return best;
    endfunction

    function automatic simplex_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [31:0] d, logic tet, logic last);
        simplex_t s;
        s.a = a; s.b = b; s.c = c;
        s.d = tet ? d : 32'd0;
        s.tet = tet;
        s.last = last;
        return s;
    endfunction

    // Appends one simplex to the tail of the expected queue.
    task automatic queue_simplex(simplex_t s);
        pending_simplices.insert(pending_simplices.size(), s);
    endtask

    // Works out the simplices of one cell and appends them to the expected queue.
    task automatic split_cell(logic [3:0] kind, logic [31:0] e [8]);
        int hex_ren [8][8] = '{'{0,1,2,3,4,5,6,7}, '{1,0,4,5,2,3,7,6},
                               '{2,1,5,6,3,0,4,7}, '{3,0,1,2,7,4,5,6},
                               '{4,0,3,7,5,1,2,6}, '{5,1,0,4,6,2,3,7},
                               '{6,2,1,5,7,3,0,4}, '{7,3,2,6,4,0,1,5}};
        int rot120 [8] = '{0,4,5,1,3,7,6,2};
        int rot240 [8] = '{0,3,7,4,1,2,6,5};
        int hex_tets [4][6][4] = '{
            '{'{0,1,2,5}, '{0,2,7,5}, '{0,2,3,7}, '{0,5,7,4}, '{2,7,5,6}, '{0,0,0,0}},
            '{'{0,5,7,4}, '{0,1,7,5}, '{1,6,7,5}, '{0,7,2,3}, '{0,7,1,2}, '{1,7,6,2}},
            '{'{0,4,5,6}, '{0,3,7,6}, '{0,7,4,6}, '{0,1,2,5}, '{0,3,6,2}, '{0,6,5,2}},
            '{'{0,2,3,6}, '{0,3,7,6}, '{0,7,4,6}, '{0,5,6,4}, '{1,5,6,0}, '{1,6,2,0}}};
        int pr_ren [6][6] = '{'{0,1,2,3,4,5}, '{1,2,0,4,5,3}, '{2,0,1,5,3,4},
                              '{3,5,4,0,2,1}, '{4,3,5,1,0,2}, '{5,4,3,2,1,0}};
        int pr_tets [2][3][4] = '{'{'{0,1,2,5}, '{0,1,5,4}, '{0,4,5,3}},
                                  '{'{0,1,2,4}, '{0,4,2,5}, '{0,4,5,3}}};
        logic [31:0] p [8];
        logic [31:0] v [8];
        logic [31:0] w [8];
        int lo, sel, bits, ndiag, cnt;
        case (kind)
            TypeQuad: begin
                if (lower_of(e[0], e[2]) < lower_of(e[1], e[3])) begin
                    queue_simplex(mk(e[0], e[1], e[2], 32'd0, 1'b0, 1'b0));
                    queue_simplex(mk(e[0], e[2], e[3], 32'd0, 1'b0, 1'b1));
                end else begin
                    queue_simplex(mk(e[1], e[2], e[3], 32'd0, 1'b0, 1'b0));
                    queue_simplex(mk(e[1], e[3], e[0], 32'd0, 1'b0, 1'b1));
                end
            end
            TypePyramid: begin
                // Base corners taken as node 0, 1, 3, 2.
                if (lower_of(e[0], e[3]) < lower_of(e[1], e[2])) begin
                    queue_simplex(mk(e[0], e[1], e[3], e[4], 1'b1, 1'b0));
                    queue_simplex(mk(e[0], e[3], e[2], e[4], 1'b1, 1'b1));
                end else begin
                    queue_simplex(mk(e[1], e[3], e[2], e[4], 1'b1, 1'b0));
                    queue_simplex(mk(e[1], e[2], e[0], e[4], 1'b1, 1'b1));
                end
            end
            TypePrism: begin
                lo = first_lowest(e, 6);
                for (int i = 0; i < 6; i++) v[i] = e[pr_ren[lo][i]];
                sel = (lower_of(v[1], v[5]) < lower_of(v[2], v[4])) ? 0 : 1;
                for (int k = 0; k < 3; k++) begin
                    queue_simplex(mk(v[pr_tets[sel][k][0]],
                        v[pr_tets[sel][k][1]], v[pr_tets[sel][k][2]],
                        v[pr_tets[sel][k][3]], 1'b1, k == 2));
                end
            end
            TypeHexa: begin
                p = '{e[0], e[1], e[3], e[2], e[4], e[5], e[7], e[6]};
                lo = first_lowest(p, 8);
                for (int i = 0; i < 8; i++) v[i] = p[hex_ren[lo][i]];
                bits = (lower_of(v[1], v[6]) < lower_of(v[2], v[5]) ? 4 : 0)
                     + (lower_of(v[3], v[6]) < lower_of(v[2], v[7]) ? 2 : 0)
                     + (lower_of(v[4], v[6]) < lower_of(v[5], v[7]) ? 1 : 0);
                for (int i = 0; i < 8; i++) begin
                    if (bits == 1 || bits == 6) w[i] = v[rot120[i]];
                    else if (bits == 2 || bits == 5) w[i] = v[rot240[i]];
                    else w[i] = v[i];
                end
                ndiag = (bits == 0) ? 0 : (bits == 7) ? 3
                      : (bits == 1 || bits == 2 || bits == 4) ? 1 : 2;
                cnt = (ndiag == 0) ? 5 : 6;
                for (int k = 0; k < cnt; k++) begin
                    queue_simplex(mk(w[hex_tets[ndiag][k][0]],
                        w[hex_tets[ndiag][k][1]], w[hex_tets[ndiag][k][2]],
                        w[hex_tets[ndiag][k][3]], 1'b1, k == cnt - 1));
                end
            end
            default: ;
        endcase
    endtask

    function automatic cell_row_t row(logic [3:0] kind, logic [31:0] n0, logic [31:0] n1,
                                      logic [31:0] n2, logic [31:0] n3, logic [31:0] n4,
                                      logic [31:0] n5, logic [31:0] n6, logic [31:0] n7);
        cell_row_t r;
        r.kind = kind;
        r.nd = '{n0, n1, n2, n3, n4, n5, n6, n7};
        r.n_known = 0;
        return r;
    endfunction

    // Sends one cell after a random gap; the predictor runs once the item is taken.
    task automatic send_cell(logic [3:0] kind, logic [31:0] nd [8]);
        repeat ($urandom_range(0, 9)) @(negedge aclk);
        s_axis_tuser = kind;
        for (int i = 0; i < 8; i++) s_axis_tdata[i*32 +: 32] = nd[i];
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        split_cell(kind, nd);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    // Random id drawn from a small pool now and then so that ties turn up.
    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        cell_row_t   plan [$];
        cell_row_t   r;
        logic [31:0] nd [8];
        logic [3:0]  kind;
        int          split_kinds [4] = '{3, 5, 8, 9};

        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        stim_done = 1'b0;
        long_stall_req = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Quad with the smallest id on the 0-2 diagonal: results can be read off.
        r = row(TypeQuad, 1, 5, 6, 7, 0, 0, 0, 0);
        r.n_known = 2;
        r.known[0] = mk(1, 5, 6, 32'd0, 1'b0, 1'b0);
        r.known[1] = mk(1, 6, 7, 32'd0, 1'b0, 1'b1);
        plan.insert(plan.size(), r);
        // Quad with all ids equal: the tie counts as not smaller.
        r = row(TypeQuad, '1, '1, '1, '1, '1, '1, '1, '1);
        r.n_known = 2;
        r.known[0] = mk('1, '1, '1, 32'd0, 1'b0, 1'b0);
        r.known[1] = mk('1, '1, '1, 32'd0, 1'b0, 1'b1);
        plan.insert(plan.size(), r);
        // Types with no split, including the unused codes.
        for (int t = 0; t < 16; t++) begin
            if (!(t inside {3, 5, 8, 9}))
                plan.insert(plan.size(), row(4'(t), '1, 0, '1, 0, '1, 0, '1, 0));
        end
        plan.insert(plan.size(), row(TypePyramid, 9, 3, 8, 1, '1, 0, 0, 0));
        plan.insert(plan.size(), row(TypePyramid, 0, 0, 0, 0, 0, '1, '1, '1));
        plan.insert(plan.size(), row(TypePrism, 6, 5, 4, 3, 2, 1, 0, 0));
        plan.insert(plan.size(), row(TypePrism, 2, 2, 2, 2, 2, 2, 7, 7));
        plan.insert(plan.size(), row(TypeHexa, 0, 1, 2, 3, 4, 5, 6, 7));
        plan.insert(plan.size(), row(TypeHexa, 7, 6, 5, 4, 3, 2, 1, 0));
        plan.insert(plan.size(), row(TypeHexa, '1, '1, '1, '1, '1, '1, '1, '1));
        plan.insert(plan.size(), row(TypeHexa, 5, 0, 3, 1, 2, 6, 4, 7));

        foreach (plan[i]) begin
            if (plan[i].n_known > 0) begin
                for (int k = 0; k < plan[i].n_known; k++)
                    queue_simplex(plan[i].known[k]);
                repeat ($urandom_range(0, 9)) @(negedge aclk);
                s_axis_tuser = plan[i].kind;
                for (int j = 0; j < 8; j++) s_axis_tdata[j*32 +: 32] = plan[i].nd[j];
                s_axis_tvalid = 1'b1;
                do @(posedge aclk); while (!s_axis_tready);
                @(negedge aclk);
                s_axis_tvalid = 1'b0;
            end else begin
                send_cell(plan[i].kind, plan[i].nd);
            end
        end

        // Random cells, mostly types that split, with a long receiver stall midway.
        for (int i = 0; i < RandomCells; i++) begin
            if (i == RandomCells / 2) long_stall_req = 1'b1;
            if ($urandom_range(0, 9) == 0) kind = 4'($urandom_range(0, 15));
            else kind = 4'(split_kinds[$urandom_range(0, 3)]);
            for (int j = 0; j < 8; j++) nd[j] = pick_id();
            // Back-to-back cells keep the input busy while the receiver holds off.
            if (long_stall_req && !stall_done) begin
                s_axis_tuser = kind;
                for (int j = 0; j < 8; j++) s_axis_tdata[j*32 +: 32] = nd[j];
                s_axis_tvalid = 1'b1;
                do @(posedge aclk); while (!s_axis_tready);
                split_cell(kind, nd);
                @(negedge aclk);
                s_axis_tvalid = 1'b0;
            end else begin
                send_cell(kind, nd);
            end
        end
        stim_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off counted in cycles.
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        stall_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_stall_req && !stall_done) begin
                m_axis_tready = 1'b0;
                repeat (300) @(negedge aclk);
                stall_done = 1'b1;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            m_axis_tready = 1'b0;
            repeat (gap) @(negedge aclk);
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!(m_axis_tvalid && aresetn));
        end
    end

    // Checks each result item against the oldest expected simplex.
    always @(posedge aclk) begin
        simplex_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_simplices.size() == 0) begin
                $error("unexpected result item: tdata %h", m_axis_tdata);
                n_errors++;
            end else begin
                want = pending_simplices.pop_front();
                if (m_axis_tdata[31:0] !== want.a) begin
                    $error("vertex_a: expected %h, got %h", want.a, m_axis_tdata[31:0]);
                    n_errors++;
                end
                if (m_axis_tdata[63:32] !== want.b) begin
                    $error("vertex_b: expected %h, got %h", want.b, m_axis_tdata[63:32]);
                    n_errors++;
                end
                if (m_axis_tdata[95:64] !== want.c) begin
                    $error("vertex_c: expected %h, got %h", want.c, m_axis_tdata[95:64]);
                    n_errors++;
                end
                if (m_axis_tdata[127:96] !== want.d) begin
                    $error("vertex_d: expected %h, got %h", want.d, m_axis_tdata[127:96]);
                    n_errors++;
                end
                if (m_axis_tuser !== want.tet) begin
                    $error("is_tetra: expected %b, got %b", want.tet, m_axis_tuser);
                    n_errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_simplex: expected %b, got %b", want.last, m_axis_tlast);
                    n_errors++;
                end
            end
        end
    end

    // End of run: drain, then a short settle so that stray items are caught.
    initial begin
        cycle_count = 0;
        while (!(stim_done && pending_simplices.size() == 0) && cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        if (cycle_count >= CycleLimit) begin
            $display("[FAIL] regression broken");
        end else begin
            repeat (DrainCycles) @(posedge aclk);
            if (n_errors == 0 && pending_simplices.size() == 0) begin
                $display("[ OK ] regression clean");
            end else begin
                $display("[FAIL] regression broken");
            end
        end
        $finish;
    end
endmodule
